// ===== hw/rtl/bbg_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the BGGR to gray block.
// No dependencies.
package bbg_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int QUEUE_DEPTH   = 4;

    // configuration register indexes
    localparam logic [7:0] CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_FRAME_HEIGHT = 8'd1;

    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    // one queued input position: window snapshot plus position flags
    typedef struct packed {
        logic [2:0][2:0][7:0] win;
        logic [15:0]          row;
        logic [12:0]          col;
        logic                 bot;   // input row is the last row
        logic                 rt;    // input column is the last column
        logic                 top1;  // input row is 1
        logic                 left1; // input column is 1
    } t_entry;

    // truncating divide by 3 for values up to 767 (reciprocal 683/2048)
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = 9'(a) + 9'(b);
        return s[8:1];
    endfunction

    function automatic logic [7:0] avg3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return div3(10'(a) + 10'(b) + 10'(c));
    endfunction

    function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d);
        logic [9:0] s;
        s = 10'(a) + 10'(b) + 10'(c) + 10'(d);
        return s[9:2];
    endfunction

endpackage

// ===== hw/rtl/bbg_front.sv =====
// Front end: geometry registers, position counters, line store and 3x3 window.
// Depends on bbg_pkg.
module bbg_front #(
    parameter int MAX_WIDTH = bbg_pkg::MAX_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_raw_pixel,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [7:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    output logic            o_push,
    output bbg_pkg::t_entry o_entry,
    input  logic            i_full
);
    import bbg_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [12:0] r_width;
    logic [15:0] r_height;
    logic [AW-1:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [2:0][2:0][7:0] r_win, n_win;
    logic [15:0] r_line_mem [MAX_WIDTH];  // {older, newer}
    logic [15:0] r_line_rd;
    logic geom_ok, accept, row_end, last_row, cfg_wr;

    assign o_in_ready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    assign geom_ok = (r_width >= 13'd2) && !r_width[0] && (32'(r_width) <= MAX_WIDTH)
                  && (r_height >= 16'd2) && !r_height[0];
    assign accept   = i_in_valid && o_in_ready && geom_ok;
    assign row_end  = (32'(r_col) + 32'd1 >= 32'(r_width));
    assign last_row = (32'(r_row) + 32'd1 >= 32'(r_height));

    // next position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr && (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT)) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = last_row ? 16'd0 : r_row + 16'd1;
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    // window after shifting in the new column
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = r_line_rd[15:8];
        n_win[1][2] = r_line_rd[7:0];
        n_win[2][2] = i_raw_pixel;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_win    <= '0;
        end else begin
            if (cfg_wr && i_cfg_index == CFG_FRAME_WIDTH) r_width <= i_cfg_data[12:0];
            if (cfg_wr && i_cfg_index == CFG_FRAME_HEIGHT) r_height <= i_cfg_data;
            r_col <= n_col;
            r_row <= n_row;
            if (accept) r_win <= n_win;
        end
    end

    // line store: read ahead at the next column, write back the current one
    always_ff @(posedge i_clk) begin
        if (accept) r_line_mem[r_col] <= {r_line_rd[7:0], i_raw_pixel};
        r_line_rd <= r_line_mem[n_col];
    end

    // queue entry for positions that emit
    assign o_push        = accept && (r_row != 16'd0) && (r_col != AW'(0));
    assign o_entry.win   = n_win;
    assign o_entry.row   = r_row;
    assign o_entry.col   = 13'(r_col);
    assign o_entry.bot   = last_row;
    assign o_entry.rt    = row_end;
    assign o_entry.top1  = (r_row == 16'd1);
    assign o_entry.left1 = (r_col == AW'(1));

endmodule

// ===== hw/rtl/bbg_queue.sv =====
// Small register queue between front and back end.
// Depends on bbg_pkg.
module bbg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bbg_pkg::t_entry i_entry,
    output logic            o_full,
    output logic            o_valid,
    output bbg_pkg::t_entry o_head,
    input  logic            i_pop
);
    import bbg_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_entry r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0] r_cnt;
    logic do_pop;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PW'(1);
            if (do_pop) r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

endmodule

// ===== hw/rtl/bbg_back.sv =====
// Back end: walks each queued position's results, rebuilds R/G/B, then gray.
// Depends on bbg_pkg.
module bbg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bbg_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_gray,
    output logic [15:0]     o_out_row,
    output logic [11:0]     o_out_col,
    output logic            o_run_last,
    output logic            o_frame_done
);
    import bbg_pkg::*;

    logic en, rowsel, colsel, last, top, bot, left, right, rodd, xodd;
    logic [1:0] r_sub, last_idx, cr, cc;
    logic [2:0][2:0][7:0] nb;
    logic [7:0] cr_v, cg_v, cb_v, diag, cross_avg, vert, horz;
    logic r_s1_valid, r_s1_last, r_s1_done;
    logic [7:0] r_s1_r, r_s1_g, r_s1_b;
    logic [15:0] r_s1_row;
    logic [11:0] r_s1_col;
    logic r_ov;

    assign en       = !r_ov || i_out_ready;
    assign last_idx = (i_head.bot && i_head.rt) ? 2'd3 :
                      ((i_head.bot || i_head.rt) ? 2'd1 : 2'd0);
    assign last     = (r_sub == last_idx);
    assign o_pop    = en && i_valid && last;
    assign rowsel   = i_head.bot && r_sub[0];
    assign colsel   = i_head.bot ? r_sub[1] : r_sub[0];

    // classify the output pixel
    assign top   = !rowsel && i_head.top1;
    assign bot   = rowsel;
    assign left  = !colsel && i_head.left1;
    assign right = colsel;
    assign rodd  = i_head.row[0] ^ !rowsel;
    assign xodd  = i_head.col[0] ^ !colsel;
    assign cr    = rowsel ? 2'd2 : 2'd1;
    assign cc    = colsel ? 2'd2 : 2'd1;

    // 3x3 neighborhood around the output pixel; the row below may not exist
    always_comb begin
        logic [1:0] wr, wc;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                wr = cr + 2'(a) - 2'd1;
                wc = cc + 2'(b) - 2'd1;
                nb[a][b] = (wr == 2'd3 || wc == 2'd3) ? 8'd0 : i_head.win[wr][wc];
            end
        end
    end

    assign diag      = avg4(nb[0][0], nb[0][2], nb[2][0], nb[2][2]);
    assign cross_avg = avg4(nb[0][1], nb[1][0], nb[1][2], nb[2][1]);
    assign vert      = avg2(nb[0][1], nb[2][1]);
    assign horz      = avg2(nb[1][0], nb[1][2]);

    // bilinear color rebuild
    always_comb begin
        cr_v = nb[1][1];
        cg_v = nb[1][1];
        cb_v = nb[1][1];
        priority if (top) begin
            priority if (left) begin
                cr_v = nb[2][2]; cg_v = avg2(nb[1][2], nb[2][1]); cb_v = nb[1][1];
            end else if (right) begin
                cr_v = nb[2][1]; cg_v = nb[1][1]; cb_v = nb[1][0];
            end else if (!xodd) begin
                cr_v = avg2(nb[2][0], nb[2][2]);
                cg_v = avg3(nb[1][0], nb[1][2], nb[2][1]);
                cb_v = nb[1][1];
            end else begin
                cr_v = nb[2][1]; cg_v = nb[1][1]; cb_v = horz;
            end
        end else if (bot) begin
            priority if (left) begin
                cr_v = nb[1][2]; cg_v = nb[1][1]; cb_v = nb[0][1];
            end else if (right) begin
                cr_v = nb[1][1]; cg_v = avg2(nb[1][0], nb[0][1]); cb_v = nb[0][0];
            end else if (!xodd) begin
                cr_v = horz; cg_v = nb[1][1]; cb_v = nb[0][1];
            end else begin
                cr_v = nb[1][1];
                cg_v = avg3(nb[1][0], nb[1][2], nb[0][1]);
                cb_v = avg2(nb[0][0], nb[0][2]);
            end
        end else begin
            priority if (left) begin
                if (!rodd) begin
                    cr_v = avg2(nb[0][2], nb[2][2]);
                    cg_v = avg3(nb[0][1], nb[2][1], nb[1][2]);
                    cb_v = nb[1][1];
                end else begin
                    cr_v = nb[1][2]; cg_v = nb[1][1]; cb_v = vert;
                end
            end else if (right) begin
                if (!rodd) begin
                    cr_v = nb[0][1]; cg_v = nb[1][1]; cb_v = nb[1][0];
                end else begin
                    cr_v = nb[1][1];
                    cg_v = avg3(nb[1][0], nb[0][1], nb[2][1]);
                    cb_v = avg2(nb[0][0], nb[2][0]);
                end
            end else begin
                unique case ({rodd, xodd})
                    2'b01: begin cr_v = vert; cg_v = nb[1][1]; cb_v = horz; end
                    2'b00: begin cr_v = diag; cg_v = cross_avg; cb_v = nb[1][1]; end
                    2'b11: begin cr_v = nb[1][1]; cg_v = cross_avg; cb_v = diag; end
                    default: begin cr_v = horz; cg_v = nb[1][1]; cb_v = vert; end
                endcase
            end
        end
    end

    // result walker and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub      <= '0;
            r_s1_valid <= 1'b0;
            r_ov       <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
            r_ov       <= r_s1_valid;
            if (i_valid) r_sub <= last ? 2'd0 : r_sub + 2'd1;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_r    <= cr_v;
            r_s1_g    <= cg_v;
            r_s1_b    <= cb_v;
            r_s1_row  <= rowsel ? i_head.row : i_head.row - 16'd1;
            r_s1_col  <= 12'(colsel ? i_head.col : i_head.col - 13'd1);
            r_s1_last <= last;
            r_s1_done <= last && i_head.bot && i_head.rt;
            o_gray       <= avg3(r_s1_r, r_s1_g, r_s1_b);
            o_out_row    <= r_s1_row;
            o_out_col    <= r_s1_col;
            o_run_last   <= r_s1_last;
            o_frame_done <= r_s1_done;
        end
    end

    assign o_out_valid = r_ov;

endmodule

// ===== hw/rtl/bayer_bggr_to_gray_unit.sv =====
// Top level of the BGGR Bayer to grayscale converter.
// Depends on bbg_pkg, bbg_front, bbg_queue, bbg_back.
//
// Raw samples enter in raster order on the input channel (valid/ready),
// one word per pixel. Gray words leave on the output channel with their row,
// column, a run_last flag on the last word caused by an input and a
// frame_done flag on the frame's final pixel. Row 0 and column 0 inputs
// produce nothing; inputs of the last row produce two words (four at the
// row end), and the last row is emitted with the row before it.
// Throughput: one input per cycle while each input yields at most one word
// and the receiver is ready; the back end emits one word per cycle unless
// stalled; inputs yielding 2 or 4 words wait in a 4-entry queue. A word
// passes the queue, the first back-end stage and the output register.
// Configuration: index 0 is frame_width, index 1 is frame_height; a write
// restarts the frame. Odd, too-small or too-wide geometry: inputs ignored.
// Reset restores 640x480 and position 0; the line store needs no clearing.
// When the receiver stalls, the output word holds, the back end freezes and
// the queue fills, then input ready drops.
module bayer_bggr_to_gray_unit #(
    parameter int MAX_WIDTH = bbg_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_raw_pixel,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_gray,
    output logic [15:0] o_out_row,
    output logic [11:0] o_out_col,
    output logic        o_run_last,
    output logic        o_frame_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import bbg_pkg::*;

    logic push, full, q_valid, pop;
    t_entry entry, head;

    bbg_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_raw_pixel(i_raw_pixel),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_push(push), .o_entry(entry), .i_full(full)
    );

    bbg_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_entry(entry), .o_full(full),
        .o_valid(q_valid), .o_head(head), .i_pop(pop)
    );

    bbg_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_head(head), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_gray(o_gray), .o_out_row(o_out_row), .o_out_col(o_out_col),
        .o_run_last(o_run_last), .o_frame_done(o_frame_done)
    );

endmodule

// ===== dv/tb_bayer_bggr_to_gray_unit.sv =====
// Self-checking testbench for bayer_bggr_to_gray_unit: directed table, then random frames.
// Depends on bbg_pkg and the RTL of bayer_bggr_to_gray_unit; gray is predicted in-bench.
module tb_bayer_bggr_to_gray_unit;
    import bbg_pkg::*;

    localparam int LINE_DEPTH  = 4096;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 12;
    localparam int RAND_ITEMS  = 220;

    // one output word
    typedef struct packed {
        logic [7:0]  gray;
        logic [15:0] row;
        logic [11:0] col;
        logic        run_last;
        logic        frame_done;
    } t_gray_word;

    // one row of the directed table
    typedef struct {
        bit          is_cfg;
        logic [7:0]  idx;
        logic [15:0] data;
        bit          rnd;
        logic [7:0]  pix;
        int          reps;
        bit          chk;
        logic [7:0]  gray_exp;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_raw_pixel;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_gray;
    logic [15:0] o_out_row;
    logic [11:0] o_out_col;
    logic        o_run_last;
    logic        o_frame_done;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    bayer_bggr_to_gray_unit dut (.*);

    // predictor state
    int unsigned mdl_width, mdl_height, mdl_col, mdl_row;
    logic [7:0]  mdl_older [LINE_DEPTH];
    logic [7:0]  mdl_newer [LINE_DEPTH];
    logic [7:0]  mdl_win [3][3];

    t_gray_word  gray_due[$];
    int          errors;
    int          cycles;
    int          burst_left;
    bit          hold_req;
    bit          chk_on;
    logic [7:0]  chk_gray;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb_bayer_bggr_to_gray_unit NOT OK");
                $finish;
            end
        end
    end

    // window sample at image (k,j), relative to current input (cur,col)
    function automatic int unsigned win_px(int unsigned cur, int unsigned col,
                                           int unsigned k, int unsigned j);
        int unsigned wr, wc;
        wr = (k + 2 - cur) & 3;
        wc = (j + 2 - col) & 16'hFFFF;
        if (wr > 2 || wc > 2) return 0;
        return mdl_win[wr][wc];
    endfunction

    // bilinear demosaic of one site, reduced to gray
    function automatic logic [7:0] site_gray(int unsigned cur, int unsigned col,
                                             int unsigned r, int unsigned x);
        int unsigned w, h, rv, gv, bv, u, d, diag, cross_avg, vert, horz;
        w = mdl_width;
        h = mdl_height;
        u = r - 1;
        d = r + 1;
        if (r == 0) begin
            if (x == 0) begin
                rv = win_px(cur, col, 1, 1);
                gv = (win_px(cur, col, 0, 1) + win_px(cur, col, 1, 0)) / 2;
                bv = win_px(cur, col, 0, 0);
            end else if (x == w - 1) begin
                rv = win_px(cur, col, 1, x);
                gv = win_px(cur, col, 0, x);
                bv = win_px(cur, col, 0, x - 1);
            end else if (!x[0]) begin
                rv = (win_px(cur, col, 1, x - 1) + win_px(cur, col, 1, x + 1)) / 2;
                gv = (win_px(cur, col, 0, x - 1) + win_px(cur, col, 0, x + 1)
                      + win_px(cur, col, 1, x)) / 3;
                bv = win_px(cur, col, 0, x);
            end else begin
                rv = win_px(cur, col, 1, x);
                gv = win_px(cur, col, 0, x);
                bv = (win_px(cur, col, 0, x - 1) + win_px(cur, col, 0, x + 1)) / 2;
            end
        end else if (r == h - 1) begin
            // bottom row: only the row above is available
            if (x == 0) begin
                rv = win_px(cur, col, r, 1);
                gv = win_px(cur, col, r, 0);
                bv = win_px(cur, col, u, 0);
            end else if (x == w - 1) begin
                rv = win_px(cur, col, r, x);
                gv = (win_px(cur, col, r, x - 1) + win_px(cur, col, u, x)) / 2;
                bv = win_px(cur, col, u, x - 1);
            end else if (!x[0]) begin
                rv = (win_px(cur, col, r, x - 1) + win_px(cur, col, r, x + 1)) / 2;
                gv = win_px(cur, col, r, x);
                bv = win_px(cur, col, u, x);
            end else begin
                rv = win_px(cur, col, r, x);
                gv = (win_px(cur, col, r, x - 1) + win_px(cur, col, r, x + 1)
                      + win_px(cur, col, u, x)) / 3;
                bv = (win_px(cur, col, u, x - 1) + win_px(cur, col, u, x + 1)) / 2;
            end
        end else if (x == 0) begin
            if (!r[0]) begin
                rv = (win_px(cur, col, u, 1) + win_px(cur, col, d, 1)) / 2;
                gv = (win_px(cur, col, u, 0) + win_px(cur, col, d, 0)
                      + win_px(cur, col, r, 1)) / 3;
                bv = win_px(cur, col, r, 0);
            end else begin
                rv = win_px(cur, col, r, 1);
                gv = win_px(cur, col, r, 0);
                bv = (win_px(cur, col, u, 0) + win_px(cur, col, d, 0)) / 2;
            end
        end else if (x == w - 1) begin
            if (!r[0]) begin
                rv = win_px(cur, col, u, x);
                gv = win_px(cur, col, r, x);
                bv = win_px(cur, col, r, x - 1);
            end else begin
                rv = win_px(cur, col, r, x);
                gv = (win_px(cur, col, r, x - 1) + win_px(cur, col, u, x)
                      + win_px(cur, col, d, x)) / 3;
                bv = (win_px(cur, col, u, x - 1) + win_px(cur, col, d, x - 1)) / 2;
            end
        end else begin
            // interior
            diag      = (win_px(cur, col, u, x - 1) + win_px(cur, col, u, x + 1)
                         + win_px(cur, col, d, x - 1) + win_px(cur, col, d, x + 1)) / 4;
            cross_avg = (win_px(cur, col, u, x) + win_px(cur, col, r, x - 1)
                         + win_px(cur, col, r, x + 1) + win_px(cur, col, d, x)) / 4;
            vert      = (win_px(cur, col, u, x) + win_px(cur, col, d, x)) / 2;
            horz      = (win_px(cur, col, r, x - 1) + win_px(cur, col, r, x + 1)) / 2;
            if (!r[0]) begin
                if (x[0]) begin
                    rv = vert; gv = win_px(cur, col, r, x); bv = horz;
                end else begin
                    rv = diag; gv = cross_avg; bv = win_px(cur, col, r, x);
                end
            end else begin
                if (x[0]) begin
                    rv = win_px(cur, col, r, x); gv = cross_avg; bv = diag;
                end else begin
                    rv = horz; gv = win_px(cur, col, r, x); bv = vert;
                end
            end
        end
        return 8'((rv + gv + bv) / 3);
    endfunction

    function automatic bit geometry_ok();
        return mdl_width >= 2 && !mdl_width[0] && mdl_width <= LINE_DEPTH
               && mdl_height >= 2 && !mdl_height[0];
    endfunction

    // advance the predictor by one accepted pixel, queue the gray words it causes
    task automatic demosaic_step(input logic [7:0] p);
        int unsigned c, r, n, idx;
        int unsigned rows [4];
        int unsigned cols [4];
        t_gray_word  wd;
        c = mdl_col;
        r = mdl_row;
        n = 0;
        if (!geometry_ok()) return;
        idx = c % LINE_DEPTH;
        for (int i = 0; i < 3; i++) begin
            mdl_win[i][0] = mdl_win[i][1];
            mdl_win[i][1] = mdl_win[i][2];
        end
        mdl_win[0][2] = mdl_older[idx];
        mdl_win[1][2] = mdl_newer[idx];
        mdl_win[2][2] = p;
        mdl_older[idx] = mdl_newer[idx];
        mdl_newer[idx] = p;
        if (r >= 1 && c >= 1) begin
            rows[n] = r - 1; cols[n] = c - 1; n++;
            if (r == mdl_height - 1) begin
                rows[n] = r; cols[n] = c - 1; n++;
            end
            if (c == mdl_width - 1) begin
                rows[n] = r - 1; cols[n] = c; n++;
                if (r == mdl_height - 1) begin
                    rows[n] = r; cols[n] = c; n++;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            wd.gray       = site_gray(r, c, rows[i], cols[i]);
            wd.row        = 16'(rows[i]);
            wd.col        = 12'(cols[i]);
            wd.run_last   = (i == n - 1);
            wd.frame_done = (i == n - 1) && r == mdl_height - 1 && c == mdl_width - 1;
            if (chk_on && wd.gray !== chk_gray) begin
                $display("%0t: table gray exp %0d act %0d", $time, chk_gray, wd.gray);
                errors++;
            end
            gray_due.push_back(wd);
        end
        if (c + 1 >= mdl_width) begin
            mdl_col = 0;
            mdl_row = (r + 1 >= mdl_height) ? 0 : r + 1;
        end else begin
            mdl_col = c + 1;
        end
    endtask

    // offer one pixel word, in bursts with random gaps
    task automatic send_pixel(input logic [7:0] p);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_raw_pixel <= p;
        do @(posedge i_clk); while (!o_in_ready);
        demosaic_step(p);
    endtask

    // wait until every queued word has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (gray_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT) begin
            if (idx == CFG_FRAME_WIDTH) mdl_width = data & 16'h1FFF;
            else mdl_height = data;
            mdl_col = 0;
            mdl_row = 0;
        end
    endtask

    // receiver: random stall pattern, plus one long hold-off on request
    initial begin
        int hold_left, run_left;
        bit all_ready;
        hold_left = 0;
        run_left = 0;
        all_ready = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (run_left == 0) begin
                run_left = $urandom_range(1, 40);
                all_ready = ($urandom_range(0, 2) == 0);
            end
            run_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= all_ready || ($urandom_range(0, 3) != 0);
            end
        end
    end

    // output checker
    initial begin
        t_gray_word act, exp_w;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                act = {o_gray, o_out_row, o_out_col, o_run_last, o_frame_done};
                if (gray_due.size() == 0) begin
                    $display("%0t: unexpected word gray %0d row %0d col %0d", $time,
                             o_gray, o_out_row, o_out_col);
                    errors++;
                end else begin
                    exp_w = gray_due.pop_front();
                    if (act !== exp_w) begin
                        $display("%0t: exp gray %0d row %0d col %0d last %b done %b",
                                 $time, exp_w.gray, exp_w.row, exp_w.col,
                                 exp_w.run_last, exp_w.frame_done);
                        $display("%0t: act gray %0d row %0d col %0d last %b done %b",
                                 $time, act.gray, act.row, act.col,
                                 act.run_last, act.frame_done);
                        errors++;
                    end
                end
            end
        end
    end

    t_stim_row plan [$];

    // main sequence
    initial begin
        int unsigned w, h, count, sent;
        bit pressed, paused;
        errors = 0;
        burst_left = 0;
        hold_req = 1'b0;
        chk_on = 1'b0;
        chk_gray = 8'd0;
        mdl_width = WIDTH_RESET;
        mdl_height = HEIGHT_RESET;
        mdl_col = 0;
        mdl_row = 0;
        foreach (mdl_win[i, j]) mdl_win[i][j] = 8'd0;
        foreach (mdl_older[i]) begin
            mdl_older[i] = 8'd0;
            mdl_newer[i] = 8'd0;
        end
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_raw_pixel <= 8'd0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= 8'd0;
        i_cfg_data  <= 16'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: {cfg, index, data, random, pixel, reps, check, gray}
        plan = '{
            // after reset: 640x480, first row gives nothing
            '{0, 0, 0, 0, 8'h00, 3, 1, 8'd0},
            '{1, CFG_FRAME_WIDTH, 16'd2, 0, 0, 0, 0, 0},
            '{1, CFG_FRAME_HEIGHT, 16'd2, 0, 0, 0, 0, 0},
            // flat white and flat black 2x2 frames
            '{0, 0, 0, 0, 8'hFF, 4, 1, 8'd255},
            '{0, 0, 0, 0, 8'h00, 4, 1, 8'd0},
            '{0, 0, 0, 0, 8'hFF, 8, 1, 8'd255},
            '{1, CFG_FRAME_WIDTH, 16'd4, 0, 0, 0, 0, 0},
            '{1, CFG_FRAME_HEIGHT, 16'd4, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 16, 0, 0},
            // unknown indexes are ignored
            '{1, 8'hFF, 16'hFFFF, 0, 0, 0, 0, 0},
            '{1, 8'hFE, 16'h0000, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 16, 0, 0},
            // bad geometry: inputs ignored
            '{1, CFG_FRAME_WIDTH, 16'd3, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 5, 0, 0},
            '{1, CFG_FRAME_WIDTH, 16'd0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 5, 0, 0},
            '{1, CFG_FRAME_WIDTH, 16'd4098, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 5, 0, 0},
            '{1, CFG_FRAME_WIDTH, 16'd4, 0, 0, 0, 0, 0},
            '{1, CFG_FRAME_HEIGHT, 16'hFFFF, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 5, 0, 0},
            '{1, CFG_FRAME_HEIGHT, 16'd1, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 5, 0, 0},
            '{1, CFG_FRAME_HEIGHT, 16'd0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 5, 0, 0},
            // wide line, shortest frame
            '{1, CFG_FRAME_WIDTH, 16'd64, 0, 0, 0, 0, 0},
            '{1, CFG_FRAME_HEIGHT, 16'd2, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 128, 0, 0},
            // narrowest line, tallest frame
            '{1, CFG_FRAME_WIDTH, 16'd2, 0, 0, 0, 0, 0},
            '{1, CFG_FRAME_HEIGHT, 16'd65534, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, 0, 40, 0, 0}
        };
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                chk_on = plan[i].chk;
                chk_gray = plan[i].gray_exp;
                repeat (plan[i].reps)
                    send_pixel(plan[i].rnd ? 8'($urandom_range(0, 255)) : plan[i].pix);
                chk_on = 1'b0;
            end
        end

        // random frames: mostly complete, some cut short, a few with bad width
        sent = 0;
        pressed = 1'b0;
        paused = 1'b0;
        while (sent < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                write_reg(CFG_FRAME_WIDTH, 16'($urandom_range(1, 8) * 2 + 1));
                repeat ($urandom_range(1, 6)) send_pixel(8'($urandom_range(0, 255)));
            end
            w = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 8) * 2;
            h = $urandom_range(1, 4) * 2;
            write_reg(CFG_FRAME_WIDTH, 16'(w));
            write_reg(CFG_FRAME_HEIGHT, 16'(h));
            count = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 5) == 0) count = $urandom_range(1, w * h);
            if (!pressed) begin
                hold_req = 1'b1;
                pressed = 1'b1;
            end
            for (int unsigned k = 0; k < count && sent < RAND_ITEMS; k++) begin
                send_pixel(8'($urandom_range(0, 255)));
                sent++;
                if (!paused && sent >= RAND_ITEMS / 2) begin
                    paused = 1'b1;
                    drain();
                end
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_bayer_bggr_to_gray_unit OK");
        end else begin
            $display("tb_bayer_bggr_to_gray_unit NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bbg_pkg.sv
hw/rtl/bbg_front.sv
hw/rtl/bbg_queue.sv
hw/rtl/bbg_back.sv
hw/rtl/bayer_bggr_to_gray_unit.sv
dv/tb_bayer_bggr_to_gray_unit.sv
